@@ hdl/i2cm_pkg.sv @@
// Shared types and constants for the I2C master transfer core.
// Depends on nothing; used by i2cm_step and i2c_master_transfer_core.
`timescale 1ns / 1ps

package i2cm_pkg;

   // Transaction kinds on the request channel (tuser)
   localparam logic [1:0] KIND_TICK   = 2'd0;
   localparam logic [1:0] KIND_BEGIN  = 2'd1;
   localparam logic [1:0] KIND_SUPPLY = 2'd2;

   // Error codes
   localparam logic [1:0] ERR_OK        = 2'd0;
   localparam logic [1:0] ERR_NACK_ADDR = 2'd1;
   localparam logic [1:0] ERR_NACK_DATA = 2'd2;
   localparam logic [1:0] ERR_NO_DATA   = 2'd3;

   // Configuration register indexes
   localparam logic CSR_LOW_TIME  = 1'b0;
   localparam logic CSR_HIGH_TIME = 1'b1;

   localparam logic [7:0] LOW_TIME_RESET  = 8'd5;
   localparam logic [7:0] HIGH_TIME_RESET = 8'd4;
   localparam logic [7:0] BYTE_ONES       = 8'hFF;
   localparam logic [7:0] BYTE_ZEROS      = 8'h00;
   localparam logic [7:0] TIMER_MAX       = 8'hFF;
   localparam logic [3:0] BITS_PER_BYTE   = 4'd8;
   localparam logic [7:0] MIN_COUNT       = 8'd2;

   typedef enum logic [12:0] {
      PH_IDLE         = 13'b0000000000001,
      PH_START_SETTLE = 13'b0000000000010,
      PH_START_HOLD   = 13'b0000000000100,
      PH_DATA_LOW     = 13'b0000000001000,
      PH_DATA_HIGH    = 13'b0000000010000,
      PH_DATA_END     = 13'b0000000100000,
      PH_ACK_LOW      = 13'b0000001000000,
      PH_ACK_HIGH     = 13'b0000010000000,
      PH_ACK_END      = 13'b0000100000000,
      PH_WAIT_BYTE    = 13'b0001000000000,
      PH_STOP_LOW     = 13'b0010000000000,
      PH_STOP_HIGH    = 13'b0100000000000,
      PH_STOP_END     = 13'b1000000000000
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] shift_reg;
      logic [3:0] bit_count;
      logic [7:0] wait_timer;
      logic [7:0] bytes_left;
      logic       read_mode;
      logic       address_phase;
      logic [1:0] last_error;
   } engine_state_type;

   typedef struct packed {
      logic [1:0] error_code;
      logic       done_res;
      logic       busy_res;
      logic       need_byte;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       sda_low;
      logic       scl_low;
   } result_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic [7:0] byte_count;
      logic       scl_in;
      logic       sda_in;
   } request_type;

endpackage

@@ hdl/i2cm_step.sv @@
// Next-state and result logic of the I2C bus sequencer for one transaction.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_step (
   input  i2cm_pkg::request_type      req,
   input  i2cm_pkg::engine_state_type cur,
   input  logic [7:0]                 low_time,
   input  logic [7:0]                 high_time,
   output i2cm_pkg::engine_state_type nxt,
   output i2cm_pkg::result_type       res
);

   logic [7:0] timer_inc;
   logic       low_hit;
   logic       high_hit;
   logic       done;
   logic       rxv;
   logic [7:0] rxb;
   logic       tx_cur;
   logic       tx_nxt;
   logic       msb_low;
   logic [7:0] bytes_dec;
   logic [3:0] bits_dec;
   logic [7:0] shifted;

   // saturating tick counter, compared against the configured times
   assign timer_inc = (cur.wait_timer != i2cm_pkg::TIMER_MAX) ? cur.wait_timer + 8'd1
                                                              : cur.wait_timer;
   assign low_hit   = timer_inc >= low_time;
   assign high_hit  = timer_inc >= high_time;
   assign tx_cur    = cur.address_phase || !cur.read_mode;
   assign bytes_dec = cur.bytes_left - 8'd1;
   assign bits_dec  = cur.bit_count - 4'd1;
   assign shifted   = {cur.shift_reg[6:0], req.sda_in};

   always_comb begin
      nxt  = cur;
      done = 1'b0;
      rxv  = 1'b0;
      rxb  = i2cm_pkg::BYTE_ZEROS;
      case (req.kind)
         i2cm_pkg::KIND_BEGIN: begin
            if (cur.phase == i2cm_pkg::PH_IDLE) begin
               nxt.last_error = i2cm_pkg::ERR_OK;
               if (req.byte_count < i2cm_pkg::MIN_COUNT) begin
                  nxt.last_error = i2cm_pkg::ERR_NO_DATA;
                  done           = 1'b1;
               end else begin
                  nxt.read_mode     = req.data_byte[0];
                  nxt.address_phase = 1'b1;
                  nxt.shift_reg     = req.data_byte;
                  nxt.bytes_left    = req.byte_count;
                  nxt.bit_count     = 4'd0;
                  nxt.wait_timer    = 8'd0;
                  nxt.phase         = i2cm_pkg::PH_START_SETTLE;
               end
            end
         end
         i2cm_pkg::KIND_SUPPLY: begin
            if (cur.phase == i2cm_pkg::PH_WAIT_BYTE) begin
               nxt.shift_reg  = req.data_byte;
               nxt.bit_count  = i2cm_pkg::BITS_PER_BYTE;
               nxt.wait_timer = 8'd0;
               nxt.phase      = i2cm_pkg::PH_DATA_LOW;
            end
         end
         i2cm_pkg::KIND_TICK: begin
            case (cur.phase)
               i2cm_pkg::PH_IDLE, i2cm_pkg::PH_WAIT_BYTE: begin
                  nxt.phase = cur.phase;
               end
               i2cm_pkg::PH_START_SETTLE: begin
                  if (req.scl_in) begin
                     nxt.wait_timer = timer_inc;
                     if (low_hit) begin
                        nxt.phase      = i2cm_pkg::PH_START_HOLD;
                        nxt.wait_timer = 8'd0;
                     end
                  end
               end
               i2cm_pkg::PH_START_HOLD: begin
                  nxt.wait_timer = timer_inc;
                  if (high_hit) begin
                     nxt.phase      = i2cm_pkg::PH_DATA_LOW;
                     nxt.wait_timer = 8'd0;
                     nxt.bit_count  = i2cm_pkg::BITS_PER_BYTE;
                  end
               end
               i2cm_pkg::PH_DATA_LOW: begin
                  nxt.wait_timer = timer_inc;
                  if (low_hit) begin
                     nxt.phase      = i2cm_pkg::PH_DATA_HIGH;
                     nxt.wait_timer = 8'd0;
                  end
               end
               i2cm_pkg::PH_DATA_HIGH: begin
                  if (req.scl_in) begin
                     nxt.wait_timer = timer_inc;
                     if (high_hit) begin
                        nxt.shift_reg  = shifted;
                        nxt.bit_count  = bits_dec;
                        nxt.wait_timer = 8'd0;
                        nxt.phase      = (bits_dec == 4'd0) ? i2cm_pkg::PH_DATA_END
                                                            : i2cm_pkg::PH_DATA_LOW;
                     end
                  end
               end
               i2cm_pkg::PH_DATA_END: begin
                  nxt.wait_timer = timer_inc;
                  if (low_hit) begin
                     nxt.wait_timer = 8'd0;
                     nxt.phase      = i2cm_pkg::PH_ACK_LOW;
                     if (!cur.address_phase && cur.read_mode) begin
                        rxv           = 1'b1;
                        rxb           = cur.shift_reg;
                        // NACK the last read byte, ACK the rest
                        nxt.shift_reg = (cur.bytes_left == 8'd1) ? i2cm_pkg::BYTE_ONES
                                                                 : i2cm_pkg::BYTE_ZEROS;
                     end else begin
                        nxt.shift_reg = i2cm_pkg::BYTE_ONES;
                     end
                  end
               end
               i2cm_pkg::PH_ACK_LOW: begin
                  nxt.wait_timer = timer_inc;
                  if (low_hit) begin
                     nxt.phase      = i2cm_pkg::PH_ACK_HIGH;
                     nxt.wait_timer = 8'd0;
                  end
               end
               i2cm_pkg::PH_ACK_HIGH: begin
                  if (req.scl_in) begin
                     nxt.wait_timer = timer_inc;
                     if (high_hit) begin
                        nxt.shift_reg  = shifted;
                        nxt.phase      = i2cm_pkg::PH_ACK_END;
                        nxt.wait_timer = 8'd0;
                     end
                  end
               end
               i2cm_pkg::PH_ACK_END: begin
                  nxt.wait_timer = timer_inc;
                  if (low_hit) begin
                     nxt.wait_timer = 8'd0;
                     nxt.shift_reg  = i2cm_pkg::BYTE_ONES;
                     if (tx_cur && cur.shift_reg[0]) begin
                        nxt.last_error = cur.address_phase ? i2cm_pkg::ERR_NACK_ADDR
                                                           : i2cm_pkg::ERR_NACK_DATA;
                        nxt.phase      = i2cm_pkg::PH_STOP_LOW;
                     end else begin
                        nxt.address_phase = 1'b0;
                        nxt.bytes_left    = bytes_dec;
                        if (bytes_dec == 8'd0) begin
                           nxt.phase = i2cm_pkg::PH_STOP_LOW;
                        end else if (cur.read_mode) begin
                           nxt.bit_count = i2cm_pkg::BITS_PER_BYTE;
                           nxt.phase     = i2cm_pkg::PH_DATA_LOW;
                        end else begin
                           nxt.phase = i2cm_pkg::PH_WAIT_BYTE;
                        end
                     end
                  end
               end
               i2cm_pkg::PH_STOP_LOW: begin
                  nxt.phase      = i2cm_pkg::PH_STOP_HIGH;
                  nxt.wait_timer = 8'd0;
               end
               i2cm_pkg::PH_STOP_HIGH: begin
                  if (req.scl_in) begin
                     nxt.wait_timer = timer_inc;
                     if (high_hit) begin
                        nxt.phase      = i2cm_pkg::PH_STOP_END;
                        nxt.wait_timer = 8'd0;
                     end
                  end
               end
               i2cm_pkg::PH_STOP_END: begin
                  nxt.wait_timer = timer_inc;
                  if (low_hit) begin
                     nxt.phase      = i2cm_pkg::PH_IDLE;
                     nxt.wait_timer = 8'd0;
                     done           = 1'b1;
                  end
               end
               default: begin
                  nxt.phase = i2cm_pkg::PH_IDLE;
               end
            endcase
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

   // Pin drive follows the state left by this transaction
   assign tx_nxt  = nxt.address_phase || !nxt.read_mode;
   assign msb_low = !nxt.shift_reg[7];

   always_comb begin
      res            = '0;
      res.rx_byte    = rxb;
      res.rx_valid   = rxv;
      res.done_res   = done;
      res.error_code = nxt.last_error;
      res.need_byte  = nxt.phase == i2cm_pkg::PH_WAIT_BYTE;
      res.busy_res   = nxt.phase != i2cm_pkg::PH_IDLE;
      res.scl_low    = (nxt.phase == i2cm_pkg::PH_DATA_LOW)  ||
                       (nxt.phase == i2cm_pkg::PH_DATA_END)  ||
                       (nxt.phase == i2cm_pkg::PH_ACK_LOW)   ||
                       (nxt.phase == i2cm_pkg::PH_ACK_END)   ||
                       (nxt.phase == i2cm_pkg::PH_WAIT_BYTE) ||
                       (nxt.phase == i2cm_pkg::PH_STOP_LOW);
      case (nxt.phase)
         i2cm_pkg::PH_START_HOLD, i2cm_pkg::PH_STOP_LOW, i2cm_pkg::PH_STOP_HIGH: begin
            res.sda_low = 1'b1;
         end
         i2cm_pkg::PH_DATA_LOW, i2cm_pkg::PH_DATA_HIGH: begin
            res.sda_low = tx_nxt && msb_low;
         end
         i2cm_pkg::PH_ACK_LOW, i2cm_pkg::PH_ACK_HIGH: begin
            res.sda_low = msb_low;
         end
         default: begin
            res.sda_low = 1'b0;
         end
      endcase
   end

endmodule

@@ hdl/i2c_master_transfer_core.sv @@
// Top level of the I2C master transfer core: handshakes, timing registers,
// sequencer state and result register. Depends on i2cm_pkg and i2cm_step.
//
//   Channel   Direction  Transaction
//   req_*     in         tick with pin samples, begin transfer, write byte
//   rsp_*     out        pin drive, received byte and status, one per request
//   csr_*     in         write of low_time_ticks (0) or high_time_ticks (1)
//
// The sequencer step is one pass of logic from the accepted request and the state
// register to the result register.
// A request is taken every cycle while the result register is empty or drained.
// A stalled rsp_tready holds the result and blocks further requests.
// Synchronous reset: sequencer idle, timing registers 5 and 4 ticks.
`timescale 1ns / 1ps

module i2c_master_transfer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] data_byte, [15:8] byte_count, [16] scl_in, [17] sda_in, [23:18] zero
   input  logic [23:0] req_tdata,
   // [1:0] kind
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] scl_low, [1] sda_low, [9:2] rx_byte, [10] rx_valid, [11] need_byte,
   // [12] busy_res, [13] done_res, [15:14] error_code
   output logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [7:0]  csr_wdata
);

   i2cm_pkg::engine_state_type state_ff;
   i2cm_pkg::engine_state_type state_in;
   i2cm_pkg::result_type       result_ff;
   i2cm_pkg::result_type       result_in;
   i2cm_pkg::request_type      req;
   logic [7:0]                 low_time_ff;
   logic [7:0]                 high_time_ff;
   logic                       rsp_valid_ff;
   logic                       accept;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign req.kind       = req_tuser;
   assign req.data_byte  = req_tdata[7:0];
   assign req.byte_count = req_tdata[15:8];
   assign req.scl_in     = req_tdata[16];
   assign req.sda_in     = req_tdata[17];

   i2cm_step u_step (
      .req       (req),
      .cur       (state_ff),
      .low_time  (low_time_ff),
      .high_time (high_time_ff),
      .nxt       (state_in),
      .res       (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         low_time_ff  <= i2cm_pkg::LOW_TIME_RESET;
         high_time_ff <= i2cm_pkg::HIGH_TIME_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            i2cm_pkg::CSR_LOW_TIME:  low_time_ff  <= csr_wdata;
            i2cm_pkg::CSR_HIGH_TIME: high_time_ff <= csr_wdata;
            default:                 low_time_ff  <= low_time_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase         <= i2cm_pkg::PH_IDLE;
         state_ff.shift_reg     <= i2cm_pkg::BYTE_ONES;
         state_ff.bit_count     <= 4'd0;
         state_ff.wait_timer    <= 8'd0;
         state_ff.bytes_left    <= 8'd0;
         state_ff.read_mode     <= 1'b0;
         state_ff.address_phase <= 1'b1;
         state_ff.last_error    <= i2cm_pkg::ERR_OK;
         rsp_valid_ff           <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         // hold the result until taken; refill on each accepted transaction
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = result_ff;

`ifndef SYNTHESIS
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted request left no result");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && result_ff.done_res) |-> !result_ff.busy_res)
      else $error("transfer reported done while still busy");

   a_need_byte_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && result_ff.need_byte) |-> (result_ff.busy_res && result_ff.scl_low))
      else $error("waiting for a write byte without holding the bus");

   a_rx_in_ack: assert property (@(posedge clock) disable iff (reset)
      (accept && result_in.rx_valid) |=> (state_ff.phase == i2cm_pkg::PH_ACK_LOW))
      else $error("received byte outside the acknowledge slot");
`endif

endmodule

@@ tb/i2c_master_transfer_core_tb.sv @@
// Self-checking testbench for i2c_master_transfer_core: a bus-step predictor
// checks every response, and a slave pin model drives the samples.
// Depends on i2cm_pkg and the core RTL only.
`timescale 1ns / 1ps

module i2c_master_transfer_core_tb;

   localparam logic [1:0] KIND_SPARE      = 2'd3;
   localparam int         STALL_LIMIT     = 5000;
   localparam int         HOLD_CYCLES     = 150;
   localparam int         RANDOM_REQUESTS = 350;

   // Predicts the pin drive and status that each request transaction produces
   class bus_step_checker;
      i2cm_pkg::phase_type  ph;
      logic [7:0] shreg, tmr, remaining, low_ticks, high_ticks;
      logic [3:0] bits_left;
      logic       rd_mode, addr_stage;
      logic [1:0] err;
      i2cm_pkg::result_type last_pins;
      i2cm_pkg::result_type pending_pins[$];
      int mismatches, requests_seen, results_seen;
      int transfers_ended, transfers_failed, bytes_read;

      function new();
         ph = i2cm_pkg::PH_IDLE;
         shreg = i2cm_pkg::BYTE_ONES;
         tmr = i2cm_pkg::BYTE_ZEROS;
         remaining = i2cm_pkg::BYTE_ZEROS;
         bits_left = 4'd0;
         rd_mode = 1'b0;
         addr_stage = 1'b1;
         err = i2cm_pkg::ERR_OK;
         low_ticks = i2cm_pkg::LOW_TIME_RESET;
         high_ticks = i2cm_pkg::HIGH_TIME_RESET;
         last_pins = '0;
         mismatches = 0;
         requests_seen = 0;
         results_seen = 0;
         transfers_ended = 0;
         transfers_failed = 0;
         bytes_read = 0;
      endfunction

      function void set_reg(logic idx, logic [7:0] val);
         if (idx == i2cm_pkg::CSR_LOW_TIME) low_ticks = val;
         else high_ticks = val;
      endfunction

      // Saturating tick counter; a limit of zero expires like one
      function bit timer_hit(logic [7:0] limit);
         if (tmr != i2cm_pkg::TIMER_MAX) tmr = tmr + 8'd1;
         return tmr >= limit;
      endfunction

      function void take_request(i2cm_pkg::request_type rq);
         logic       finished, rxv, tx, nack;
         logic [7:0] rxb;
         i2cm_pkg::result_type r;
         finished = 1'b0;
         rxv = 1'b0;
         rxb = i2cm_pkg::BYTE_ZEROS;
         requests_seen++;
         case (rq.kind)
            i2cm_pkg::KIND_BEGIN: begin
               if (ph == i2cm_pkg::PH_IDLE) begin
                  err = i2cm_pkg::ERR_OK;
                  if (rq.byte_count < i2cm_pkg::MIN_COUNT) begin
                     err = i2cm_pkg::ERR_NO_DATA;
                     finished = 1'b1;
                  end else begin
                     rd_mode = rq.data_byte[0];
                     addr_stage = 1'b1;
                     shreg = rq.data_byte;
                     remaining = rq.byte_count;
                     bits_left = 4'd0;
                     tmr = i2cm_pkg::BYTE_ZEROS;
                     ph = i2cm_pkg::PH_START_SETTLE;
                  end
               end
            end
            i2cm_pkg::KIND_SUPPLY: begin
               if (ph == i2cm_pkg::PH_WAIT_BYTE) begin
                  shreg = rq.data_byte;
                  bits_left = i2cm_pkg::BITS_PER_BYTE;
                  tmr = i2cm_pkg::BYTE_ZEROS;
                  ph = i2cm_pkg::PH_DATA_LOW;
               end
            end
            i2cm_pkg::KIND_TICK: begin
               case (ph)
                  i2cm_pkg::PH_START_SETTLE: begin
                     if (rq.scl_in && timer_hit(low_ticks)) begin
                        ph = i2cm_pkg::PH_START_HOLD;
                        tmr = i2cm_pkg::BYTE_ZEROS;
                     end
                  end
                  i2cm_pkg::PH_START_HOLD: begin
                     if (timer_hit(high_ticks)) begin
                        ph = i2cm_pkg::PH_DATA_LOW;
                        tmr = i2cm_pkg::BYTE_ZEROS;
                        bits_left = i2cm_pkg::BITS_PER_BYTE;
                     end
                  end
                  i2cm_pkg::PH_DATA_LOW: begin
                     if (timer_hit(low_ticks)) begin
                        ph = i2cm_pkg::PH_DATA_HIGH;
                        tmr = i2cm_pkg::BYTE_ZEROS;
                     end
                  end
                  i2cm_pkg::PH_DATA_HIGH: begin
                     if (rq.scl_in && timer_hit(high_ticks)) begin
                        shreg = {shreg[6:0], rq.sda_in};
                        bits_left = bits_left - 4'd1;
                        tmr = i2cm_pkg::BYTE_ZEROS;
                        if (bits_left == 4'd0) ph = i2cm_pkg::PH_DATA_END;
                        else ph = i2cm_pkg::PH_DATA_LOW;
                     end
                  end
                  i2cm_pkg::PH_DATA_END: begin
                     if (timer_hit(low_ticks)) begin
                        tmr = i2cm_pkg::BYTE_ZEROS;
                        if (!addr_stage && rd_mode) begin
                           rxv = 1'b1;
                           rxb = shreg;
                           // answer NACK on the final read byte, ACK otherwise
                           shreg = (remaining == 8'd1) ? i2cm_pkg::BYTE_ONES
                                                       : i2cm_pkg::BYTE_ZEROS;
                        end else begin
                           shreg = i2cm_pkg::BYTE_ONES;
                        end
                        ph = i2cm_pkg::PH_ACK_LOW;
                     end
                  end
                  i2cm_pkg::PH_ACK_LOW: begin
                     if (timer_hit(low_ticks)) begin
                        ph = i2cm_pkg::PH_ACK_HIGH;
                        tmr = i2cm_pkg::BYTE_ZEROS;
                     end
                  end
                  i2cm_pkg::PH_ACK_HIGH: begin
                     if (rq.scl_in && timer_hit(high_ticks)) begin
                        shreg = {shreg[6:0], rq.sda_in};
                        ph = i2cm_pkg::PH_ACK_END;
                        tmr = i2cm_pkg::BYTE_ZEROS;
                     end
                  end
                  i2cm_pkg::PH_ACK_END: begin
                     if (timer_hit(low_ticks)) begin
                        nack = (addr_stage || !rd_mode) && shreg[0];
                        tmr = i2cm_pkg::BYTE_ZEROS;
                        shreg = i2cm_pkg::BYTE_ONES;
                        if (nack) begin
                           err = addr_stage ? i2cm_pkg::ERR_NACK_ADDR : i2cm_pkg::ERR_NACK_DATA;
                           ph = i2cm_pkg::PH_STOP_LOW;
                        end else begin
                           addr_stage = 1'b0;
                           remaining = remaining - 8'd1;
                           if (remaining == i2cm_pkg::BYTE_ZEROS) ph = i2cm_pkg::PH_STOP_LOW;
                           else if (rd_mode) begin
                              bits_left = i2cm_pkg::BITS_PER_BYTE;
                              ph = i2cm_pkg::PH_DATA_LOW;
                           end else ph = i2cm_pkg::PH_WAIT_BYTE;
                        end
                     end
                  end
                  i2cm_pkg::PH_STOP_LOW: begin
                     ph = i2cm_pkg::PH_STOP_HIGH;
                     tmr = i2cm_pkg::BYTE_ZEROS;
                  end
                  i2cm_pkg::PH_STOP_HIGH: begin
                     if (rq.scl_in && timer_hit(high_ticks)) begin
                        ph = i2cm_pkg::PH_STOP_END;
                        tmr = i2cm_pkg::BYTE_ZEROS;
                     end
                  end
                  i2cm_pkg::PH_STOP_END: begin
                     if (timer_hit(low_ticks)) begin
                        ph = i2cm_pkg::PH_IDLE;
                        tmr = i2cm_pkg::BYTE_ZEROS;
                        finished = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase

         tx = addr_stage || !rd_mode;
         r = '0;
         r.scl_low = ph inside {i2cm_pkg::PH_DATA_LOW, i2cm_pkg::PH_DATA_END,
                                i2cm_pkg::PH_ACK_LOW, i2cm_pkg::PH_ACK_END,
                                i2cm_pkg::PH_WAIT_BYTE, i2cm_pkg::PH_STOP_LOW};
         case (ph)
            i2cm_pkg::PH_START_HOLD, i2cm_pkg::PH_STOP_LOW, i2cm_pkg::PH_STOP_HIGH:
               r.sda_low = 1'b1;
            i2cm_pkg::PH_DATA_LOW, i2cm_pkg::PH_DATA_HIGH: r.sda_low = tx && !shreg[7];
            i2cm_pkg::PH_ACK_LOW, i2cm_pkg::PH_ACK_HIGH: r.sda_low = !shreg[7];
            default: r.sda_low = 1'b0;
         endcase
         r.rx_valid = rxv;
         r.rx_byte = rxv ? rxb : i2cm_pkg::BYTE_ZEROS;
         r.need_byte = (ph == i2cm_pkg::PH_WAIT_BYTE);
         r.busy_res = (ph != i2cm_pkg::PH_IDLE);
         r.done_res = finished;
         r.error_code = err;
         if (finished) begin
            transfers_ended++;
            if (err != i2cm_pkg::ERR_OK) transfers_failed++;
         end
         if (rxv) bytes_read++;
         last_pins = r;
         pending_pins.push_back(r);
      endfunction

      function void compare_field(string label, int want, int got);
         if (want != got) begin
            $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, label, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(i2cm_pkg::result_type got);
         i2cm_pkg::result_type want;
         results_seen++;
         if (pending_pins.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            mismatches++;
            return;
         end
         want = pending_pins.pop_front();
         compare_field("scl_low", want.scl_low, got.scl_low);
         compare_field("sda_low", want.sda_low, got.sda_low);
         compare_field("rx_byte", want.rx_byte, got.rx_byte);
         compare_field("rx_valid", want.rx_valid, got.rx_valid);
         compare_field("need_byte", want.need_byte, got.need_byte);
         compare_field("busy_res", want.busy_res, got.busy_res);
         compare_field("done_res", want.done_res, got.done_res);
         compare_field("error_code", want.error_code, got.error_code);
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = i2cm_pkg::KIND_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic        csr_addr = i2cm_pkg::CSR_LOW_TIME;
   logic [7:0]  csr_wdata = '0;

   bus_step_checker board = new();
   bit gaps_on = 1'b1;
   bit hold_request = 1'b0;
   int holdoffs = 0;

   i2c_master_transfer_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Offer one request transaction, with an occasional idle burst first
   task automatic offer(i2cm_pkg::request_type rq);
      if (gaps_on && $urandom_range(0, 99) < 7) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, rq.sda_in, rq.scl_in, rq.byte_count, rq.data_byte};
      req_tuser <= rq.kind;
      do @(posedge clock); while (!req_tready);
      board.take_request(rq);
   endtask

   // Hold off new requests until every response has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending_pins.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [7:0] val);
      drain();
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      board.set_reg(idx, val);
      csr_we <= 1'b0;
   endtask

   // Item that does not belong to a well-formed sequence
   function automatic i2cm_pkg::request_type stray_item();
      i2cm_pkg::request_type rq;
      rq = '0;
      rq.data_byte = 8'($urandom_range(0, 255));
      rq.byte_count = 8'($urandom_range(0, 255));
      rq.scl_in = 1'($urandom_range(0, 1));
      rq.sda_in = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0: rq.kind = i2cm_pkg::KIND_BEGIN;
         1: rq.kind = i2cm_pkg::KIND_SUPPLY;
         2: rq.kind = i2cm_pkg::KIND_TICK;
         default: rq.kind = KIND_SPARE;
      endcase
      return rq;
   endfunction

   // Wired-AND bus: the master drive from the last response plus a slave model
   function automatic i2cm_pkg::request_type bus_tick(int stretch_pct, bit refuse);
      i2cm_pkg::request_type rq;
      bit slave_low;
      rq = '0;
      rq.kind = i2cm_pkg::KIND_TICK;
      rq.data_byte = 8'($urandom_range(0, 255));
      rq.byte_count = 8'($urandom_range(0, 255));
      rq.scl_in = !board.last_pins.scl_low && ($urandom_range(0, 99) >= stretch_pct);
      slave_low = 1'b0;
      if (board.ph inside {i2cm_pkg::PH_ACK_LOW, i2cm_pkg::PH_ACK_HIGH} &&
          (board.addr_stage || !board.rd_mode))
         slave_low = !refuse;
      else if (board.ph inside {i2cm_pkg::PH_DATA_LOW, i2cm_pkg::PH_DATA_HIGH} &&
               board.rd_mode && !board.addr_stage)
         slave_low = 1'($urandom_range(0, 1));
      rq.sda_in = !(board.last_pins.sda_low || slave_low);
      // rare line glitches
      if ($urandom_range(0, 99) < 2) rq.sda_in = !rq.sda_in;
      if ($urandom_range(0, 99) < 1) rq.scl_in = !rq.scl_in;
      return rq;
   endfunction

   // Tick the bus until the sequencer reaches the given phase
   task automatic tick_until(i2cm_pkg::phase_type target);
      while (board.ph != target) offer(bus_tick(0, 1'b0));
   endtask

   task automatic finish_transfer(int stretch_pct, int nack_addr_pct, int nack_data_pct,
                                  int noise_pct);
      i2cm_pkg::request_type rq;
      bit refuse;
      refuse = 1'b0;
      while (board.ph != i2cm_pkg::PH_IDLE) begin
         if (board.ph == i2cm_pkg::PH_DATA_END)
            refuse = $urandom_range(0, 99) <
                     (board.addr_stage ? nack_addr_pct : nack_data_pct);
         if ($urandom_range(0, 99) < noise_pct) rq = stray_item();
         else if (board.ph == i2cm_pkg::PH_WAIT_BYTE && $urandom_range(0, 3) != 0) begin
            rq = '0;
            rq.kind = i2cm_pkg::KIND_SUPPLY;
            rq.data_byte = 8'($urandom_range(0, 255));
         end else rq = bus_tick(stretch_pct, refuse);
         offer(rq);
      end
   endtask

   task automatic start_transfer(logic [7:0] addr, logic [7:0] count);
      i2cm_pkg::request_type rq;
      rq = '0;
      rq.kind = i2cm_pkg::KIND_BEGIN;
      rq.data_byte = addr;
      rq.byte_count = count;
      rq.scl_in = 1'($urandom_range(0, 1));
      rq.sda_in = 1'($urandom_range(0, 1));
      offer(rq);
   endtask

   task automatic run_transfer(logic [7:0] addr, logic [7:0] count, int stretch_pct,
                               int nack_addr_pct, int nack_data_pct, int noise_pct);
      start_transfer(addr, count);
      finish_transfer(stretch_pct, nack_addr_pct, nack_data_pct, noise_pct);
   endtask

   function automatic logic [7:0] pick_timing();
      if ($urandom_range(0, 9) == 0) return i2cm_pkg::BYTE_ZEROS;
      return 8'($urandom_range(1, 3));
   endfunction

   // Response side: random stalls plus one long hold-off on request
   initial begin : receiver
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) board.check_result(i2cm_pkg::result_type'(rsp_tdata));
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            holdoffs++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 99) < 6) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_tready <= 1'b0;
         end else rsp_tready <= 1'b1;
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet);
            $display("i2c_master_transfer_core_tb: done, errors");
            $finish;
         end
      end
   end

   initial begin : stimulus
      i2cm_pkg::request_type rq;
      int random_from;
      bit pressed;
      logic [7:0] count;
      pressed = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // idle-state oddities: spare kind, supply and tick with nothing running
      rq = '0;
      rq.kind = KIND_SPARE;
      offer(rq);
      rq.kind = i2cm_pkg::KIND_SUPPLY;
      rq.data_byte = i2cm_pkg::BYTE_ONES;
      offer(rq);
      rq = '0;
      rq.kind = i2cm_pkg::KIND_TICK;
      rq.scl_in = 1'b1;
      offer(rq);
      // count under two ends at once with an error
      rq = '0;
      rq.kind = i2cm_pkg::KIND_BEGIN;
      rq.data_byte = i2cm_pkg::BYTE_ONES;
      offer(rq);
      rq.data_byte = i2cm_pkg::BYTE_ZEROS;
      rq.byte_count = 8'd1;
      offer(rq);
      rq = '0;
      rq.kind = i2cm_pkg::KIND_TICK;
      offer(rq);

      // reset timing through the start condition, then the fastest timing
      start_transfer(8'hA0, 8'd2);
      tick_until(i2cm_pkg::PH_DATA_LOW);
      write_reg(i2cm_pkg::CSR_LOW_TIME, 8'd1);
      write_reg(i2cm_pkg::CSR_HIGH_TIME, 8'd1);
      finish_transfer(0, 0, 0, 0);
      run_transfer(8'hA1, 8'd3, 20, 0, 0, 0);
      run_transfer(8'h42, 8'd3, 0, 100, 0, 0);
      run_transfer(8'h42, 8'd4, 0, 0, 100, 0);
      run_transfer(8'hBD, 8'd3, 10, 0, 0, 10);
      run_transfer(8'h5E, 8'd4, 5, 0, 0, 0);
      run_transfer(8'h5F, 8'd4, 5, 0, 0, 0);
      // zero timing behaves as one tick
      write_reg(i2cm_pkg::CSR_LOW_TIME, i2cm_pkg::BYTE_ZEROS);
      write_reg(i2cm_pkg::CSR_HIGH_TIME, i2cm_pkg::BYTE_ZEROS);
      run_transfer(8'h30, 8'd3, 10, 0, 0, 0);
      // slowest settings through the start condition, then back to fast
      write_reg(i2cm_pkg::CSR_LOW_TIME, i2cm_pkg::TIMER_MAX);
      write_reg(i2cm_pkg::CSR_HIGH_TIME, i2cm_pkg::TIMER_MAX);
      start_transfer(8'h72, 8'd2);
      tick_until(i2cm_pkg::PH_DATA_LOW);
      write_reg(i2cm_pkg::CSR_LOW_TIME, 8'd1);
      write_reg(i2cm_pkg::CSR_HIGH_TIME, 8'd1);
      finish_transfer(0, 0, 0, 0);

      random_from = board.requests_seen;
      while (board.requests_seen - random_from < RANDOM_REQUESTS) begin
         if (!pressed || $urandom_range(0, 5) == 0) begin
            write_reg(i2cm_pkg::CSR_LOW_TIME, pick_timing());
            write_reg(i2cm_pkg::CSR_HIGH_TIME, pick_timing());
         end
         if (pressed && $urandom_range(0, 6) == 0) begin
            rq = stray_item();
            if (rq.kind == i2cm_pkg::KIND_BEGIN) rq.byte_count = 8'($urandom_range(0, 3));
            offer(rq);
            finish_transfer($urandom_range(0, 30), 8, 8, 3);
         end else begin
            count = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(5, 10))
                                                : 8'($urandom_range(2, 4));
            // first random transfer runs into a long response hold-off
            if (!pressed) hold_request = 1'b1;
            pressed = 1'b1;
            run_transfer(8'($urandom_range(0, 255)), count, $urandom_range(0, 30), 8, 8, 3);
         end
      end

      // closing stretch at full rate
      write_reg(i2cm_pkg::CSR_LOW_TIME, 8'd1);
      write_reg(i2cm_pkg::CSR_HIGH_TIME, 8'd1);
      gaps_on = 1'b0;
      run_transfer(8'h90, 8'd3, 0, 0, 0, 0);
      run_transfer(8'h91, 8'd3, 0, 0, 0, 0);
      run_transfer(8'h92, 8'd2, 0, 0, 50, 0);

      drain();
      repeat (4) @(posedge clock);
      $display("Covered %0d requests and %0d responses, %0d long response hold-offs.",
               board.requests_seen, board.results_seen, holdoffs);
      $display("Transfers ended: %0d, %0d of them with an error; %0d bytes read.",
               board.transfers_ended, board.transfers_failed, board.bytes_read);
      if (board.mismatches == 0 && board.pending_pins.size() == 0)
         $display("i2c_master_transfer_core_tb: done, clean");
      else
         $display("i2c_master_transfer_core_tb: done, errors");
      $finish;
   end

endmodule
